[src/bdq_pkg.sv]
// shared types, constants and ring index helpers for the bounded deque
// no dependencies
package bdq_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int FOUND_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 48;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // command codes; 6 and 7 act as no-ops
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_SIZE       = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    ins_front;
    logic    ins_back;
    logic    rem_front;
    logic    rem_back;
    logic    take_rdata;
    logic    srch_start;
    logic    srch_step;
    logic    take_found;
    logic    st_set;
    status_e st_code;
    logic    publish;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             match;
    logic             scan_done;
  } dp_stat_t;

  localparam logic [ADDR_W:0] CAP_L  = (ADDR_W + 1)'(CAPACITY);
  localparam addr_t           LAST_A = ADDR_W'(CAPACITY - 1);

  // ring add of two offsets that are both below the capacity
  function automatic addr_t ring_add(input addr_t a, input addr_t b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_L) begin
      s = s - CAP_L;
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic addr_t ring_inc(input addr_t a);
    return (a == LAST_A) ? '0 : addr_t'(a + 1'b1);
  endfunction

  function automatic addr_t ring_dec(input addr_t a);
    return (a == '0) ? LAST_A : addr_t'(a - 1'b1);
  endfunction

endpackage

[src/bdq_datapath.sv]
// element memory, ring pointers, search scan and result registers
// depends on bdq_pkg
module bdq_datapath import bdq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VAL_W-1:0]    in_val,
  input  dp_ctl_t             ctl,
  output dp_stat_t            stat,
  output logic [M_DATA_W-1:0] res_data
);

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata;
  logic [CMD_W-1:0]  cmd_r;
  logic [VAL_W-1:0]  val_r;
  addr_t             front;
  cnt_t              count;
  cnt_t              srch_idx;
  cnt_t              cmp_idx;
  logic              rd_vld;
  status_e           pend_status;
  logic [VAL_W-1:0]  pend_removed;
  cnt_t              pend_found;
  logic [STAT_W-1:0]  res_status;
  logic [VAL_W-1:0]   res_removed;
  logic [FOUND_W-1:0] res_found;
  logic [COUNT_W-1:0] res_count;

  addr_t front_m1;
  addr_t wr_addr;
  addr_t rd_addr;
  logic  wr_en;
  logic  rd_en;
  logic  issue;

  // address selection for the single write and read ports
  always_comb begin
    front_m1 = ring_dec(front);
    wr_addr  = ctl.ins_front ? front_m1 : ring_add(front, count[ADDR_W-1:0]);
    wr_en    = ctl.ins_front | ctl.ins_back;
    issue    = ctl.srch_step && (srch_idx < count);
    if (ctl.rem_back) begin
      rd_addr = ring_add(front, addr_t'(count - 1'b1));
    end else if (ctl.srch_step) begin
      rd_addr = ring_add(front, srch_idx[ADDR_W-1:0]);
    end else begin
      rd_addr = front;
    end
    rd_en = ctl.rem_front | ctl.rem_back | issue;
  end

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (ctl.ins_front) begin
        front <= front_m1;
      end else if (ctl.rem_front) begin
        front <= ring_inc(front);
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end else if (ctl.rem_front | ctl.rem_back) begin
        count <= count - 1'b1;
      end
    end
  end

  // search scan: issue one read per cycle, compare the previous one
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (ctl.srch_start) begin
      rd_vld <= 1'b0;
    end else if (ctl.srch_step) begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_start) begin
      srch_idx <= '0;
    end else if (issue) begin
      srch_idx <= srch_idx + 1'b1;
    end
    if (issue) begin
      cmp_idx <= srch_idx;
    end
  end

  // current command and pending result fields
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r        <= in_cmd;
      val_r        <= in_val;
      pend_removed <= '0;
      pend_found   <= '0;
    end else begin
      if (ctl.take_rdata) begin
        pend_removed <= rdata;
      end
      if (ctl.take_found) begin
        pend_found <= cmp_idx;
      end
    end
    if (ctl.st_set) begin
      pend_status <= ctl.st_code;
    end
  end

  // output register, count taken after the operation
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      res_status  <= pend_status;
      res_removed <= pend_removed;
      res_found   <= FOUND_W'(pend_found);
      res_count   <= COUNT_W'(count);
    end
  end

  assign res_data = {1'b0, res_count, res_found, res_removed, res_status};

  always_comb begin
    stat.cmd       = cmd_r;
    stat.empty     = (count == '0);
    stat.full      = (count >= cnt_t'(CAPACITY));
    stat.match     = rd_vld && (rdata == val_r);
    stat.scan_done = !rd_vld && (srch_idx == count);
  end

endmodule

[src/bdq_ctrl.sv]
// command sequencer and output beat control for the bounded deque
// depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPWAIT,
    S_SRCH,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  // command decode per state
  always_comb begin
    ctl        = '0;
    ctl.st_code = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.st_set = 1'b1;
        state_next = S_FINISH;
        case (stat.cmd)
          CMD_PUSH_FRONT: begin
            if (stat.full) ctl.st_code = ST_FULL;
            else ctl.ins_front = 1'b1;
          end
          CMD_PUSH_BACK: begin
            if (stat.full) ctl.st_code = ST_FULL;
            else ctl.ins_back = 1'b1;
          end
          CMD_POP_FRONT: begin
            if (stat.empty) begin
              ctl.st_code = ST_EMPTY;
            end else begin
              ctl.rem_front = 1'b1;
              state_next    = S_POPWAIT;
            end
          end
          CMD_POP_BACK: begin
            if (stat.empty) begin
              ctl.st_code = ST_EMPTY;
            end else begin
              ctl.rem_back = 1'b1;
              state_next   = S_POPWAIT;
            end
          end
          CMD_SEARCH: begin
            if (stat.empty) begin
              ctl.st_code = ST_EMPTY;
            end else begin
              ctl.srch_start = 1'b1;
              state_next     = S_SRCH;
            end
          end
          CMD_SIZE: begin
            if (stat.empty) ctl.st_code = ST_EMPTY;
          end
          default: begin
            ctl.st_code = ST_OK;
          end
        endcase
      end
      S_POPWAIT: begin
        ctl.take_rdata = 1'b1;
        state_next     = S_FINISH;
      end
      S_SRCH: begin
        ctl.srch_step = 1'b1;
        if (stat.match) begin
          ctl.take_found = 1'b1;
          ctl.st_set     = 1'b1;
          ctl.st_code    = ST_OK;
          state_next     = S_FINISH;
        end else if (stat.scan_done) begin
          ctl.st_set  = 1'b1;
          ctl.st_code = ST_NOTFOUND;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.publish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/bounded_deque_with_search.sv]
// Bounded double-ended queue of signed 32-bit values held in a 64-entry ring
// memory, with push and pop at either end, first-match search and size query.
// One command is worked at a time and each gives exactly one result beat.
// A search scans the stored elements in order until the first match, reading
// one entry per cycle through the memory's single read port. The result sits
// in an output register, so the next command is worked while a result still
// waits on m_tready. No clearing pass is needed after reset.
// depends on bdq_pkg, bdq_ctrl, bdq_datapath
module bounded_deque_with_search import bdq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // command[2:0], value[34:3], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // status[1:0], removed_value[33:2],
                                        // found_index[39:34],
                                        // element_count[46:40], zero pad
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bdq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (s_tdata[CMD_W-1:0]),
    .in_val   (s_tdata[CMD_W+VAL_W-1:CMD_W]),
    .ctl      (ctl),
    .stat     (stat),
    .res_data (m_tdata)
  );

  // one command in flight: a beat accepted closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command is in flight");

  // a full status reports a full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_FULL) |-> (m_tdata[46:40] == COUNT_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  // an empty status reports a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_EMPTY) |-> (m_tdata[46:40] == '0))
    else $error("empty status with a nonzero count");

  // the pointer logic never reports full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("count reads both full and empty");

endmodule

[bench/tb_bounded_deque_with_search.sv]
// self-checking bench for bounded_deque_with_search: command stream in, result beats out
// depends on bdq_pkg for widths, command and status codes; needs only the RTL
module tb_bounded_deque_with_search import bdq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS  = 1450;
  localparam int MAX_GAP      = 13;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PEND_DEPTH   = 16;

  // spare command codes that the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // result beat bit offsets
  localparam int RM_LSB = STAT_W;
  localparam int FI_LSB = RM_LSB + VAL_W;
  localparam int EC_LSB = FI_LSB + FOUND_W;

  typedef struct packed {
    status_e              status;
    logic [VAL_W-1:0]     removed;
    logic [FOUND_W-1:0]   found;
    logic [COUNT_W-1:0]   count;
  } deque_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    bit               known;
    deque_result_t    res;
  } stim_row_t;

  localparam deque_result_t NO_RES = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  bounded_deque_with_search u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // mirror of the deque contents
  logic [VAL_W-1:0] shadow_ring [CAPACITY];
  int               shadow_front = 0;
  int               shadow_count = 0;

  // expected results in issue order, a few in flight at most
  deque_result_t pending_results [PEND_DEPTH];
  int            pend_wr = 0;
  int            pend_rd = 0;
  int            mismatch_cnt = 0;
  int            sent_items = 0;
  int            idle_cycles = 0;
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;

  // directed rows: empty-list cases, sole-element pops, extremes, search order
  stim_row_t directed_rows [24] = '{
    '{CMD_SIZE,       32'h0,        1'b1, '{ST_EMPTY, 32'h0,        6'd0, 7'd0}},
    '{CMD_POP_FRONT,  32'hffffffff, 1'b1, '{ST_EMPTY, 32'h0,        6'd0, 7'd0}},
    '{CMD_POP_BACK,   32'hffffffff, 1'b1, '{ST_EMPTY, 32'h0,        6'd0, 7'd0}},
    '{CMD_SEARCH,     32'h0,        1'b1, '{ST_EMPTY, 32'h0,        6'd0, 7'd0}},
    '{CMD_SPARE_LO,   32'h12345678, 1'b1, '{ST_OK,    32'h0,        6'd0, 7'd0}},
    '{CMD_PUSH_BACK,  32'h7fffffff, 1'b1, '{ST_OK,    32'h0,        6'd0, 7'd1}},
    '{CMD_POP_FRONT,  32'h0,        1'b1, '{ST_OK,    32'h7fffffff, 6'd0, 7'd0}},
    '{CMD_PUSH_FRONT, 32'h80000000, 1'b1, '{ST_OK,    32'h0,        6'd0, 7'd1}},
    '{CMD_POP_BACK,   32'h0,        1'b1, '{ST_OK,    32'h80000000, 6'd0, 7'd0}},
    '{CMD_SIZE,       32'hffffffff, 1'b1, '{ST_EMPTY, 32'h0,        6'd0, 7'd0}},
    '{CMD_PUSH_FRONT, 32'hffffffff, 1'b0, NO_RES},
    '{CMD_PUSH_BACK,  32'h0,        1'b0, NO_RES},
    '{CMD_PUSH_FRONT, 32'h1,        1'b0, NO_RES},
    '{CMD_PUSH_BACK,  32'h80000000, 1'b0, NO_RES},
    '{CMD_SEARCH,     32'h80000000, 1'b0, NO_RES},
    '{CMD_SEARCH,     32'h1,        1'b0, NO_RES},
    '{CMD_SEARCH,     32'h7fffffff, 1'b0, NO_RES},
    '{CMD_PUSH_BACK,  32'hffffffff, 1'b0, NO_RES},
    '{CMD_SEARCH,     32'hffffffff, 1'b0, NO_RES},
    '{CMD_SPARE_HI,   32'hffffffff, 1'b0, NO_RES},
    '{CMD_SIZE,       32'h0,        1'b0, NO_RES},
    '{CMD_POP_BACK,   32'h0,        1'b0, NO_RES},
    '{CMD_POP_FRONT,  32'hffffffff, 1'b0, NO_RES},
    '{CMD_SEARCH,     32'haaaaaaaa, 1'b0, NO_RES}
  };

  // apply one command to the mirror and return the result it should give
  function automatic deque_result_t deque_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [VAL_W-1:0] val);
    deque_result_t r;
    int            pos;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
          shadow_ring[shadow_front] = val;
          shadow_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_count) % CAPACITY] = val;
          shadow_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % CAPACITY;
          shadow_count--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = shadow_ring[(shadow_front + shadow_count - 1) % CAPACITY];
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (pos = 0; pos < shadow_count; pos++) begin
            if (shadow_ring[(shadow_front + pos) % CAPACITY] == val) begin
              r.status = ST_OK;
              r.found = FOUND_W'(pos);
              break;
            end
          end
        end
      end
      CMD_SIZE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  // element values biased toward extremes and small repeats
  function automatic logic [VAL_W-1:0] draw_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h80000000;
      1: v = 32'h7fffffff;
      2: v = VAL_W'($urandom_range(0, 7));
      3: v = 32'hffffffff - VAL_W'($urandom_range(0, 7));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // search key: mostly a value that is held, sometimes anything
  function automatic logic [VAL_W-1:0] draw_key();
    logic [VAL_W-1:0] v;
    if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
      v = shadow_ring[(shadow_front + $urandom_range(0, shadow_count - 1)) % CAPACITY];
    end else begin
      v = draw_value();
    end
    return v;
  endfunction

  // send one command beat and queue what it should produce
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                               input bit known, input deque_result_t typed_res);
    int            gap;
    deque_result_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - CMD_W - VAL_W){1'b0}}, val, cmd};
    do @(posedge clk); while (!s_tready);
    predicted = deque_apply(cmd, val);
    pending_results[pend_wr % PEND_DEPTH] = known ? typed_res : predicted;
    pend_wr++;
    sent_items++;
  endtask

  // hold the sender off until every queued result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pend_wr != pend_rd);
  endtask

  task automatic report_field(input string field_name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
      mismatch_cnt++;
    end
  endtask

  // count cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int            stall;
    int            rx_left;
    deque_result_t want;
    deque_result_t got;
    rx_left = 0;
    wait (rst == 1'b0);
    forever begin
      if (rx_left == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
        rx_left  = $urandom_range(20, 80);
      end
      rx_left--;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.status  = status_e'(m_tdata[STAT_W-1:0]);
      got.removed = m_tdata[RM_LSB +: VAL_W];
      got.found   = m_tdata[FI_LSB +: FOUND_W];
      got.count   = m_tdata[EC_LSB +: COUNT_W];
      if (pend_wr == pend_rd) begin
        $display("%0t: unexpected result beat, expected none actual %0h", $time, m_tdata);
        mismatch_cnt++;
      end else begin
        want = pending_results[pend_rd % PEND_DEPTH];
        pend_rd++;
        report_field("status", VAL_W'(want.status), VAL_W'(got.status));
        report_field("removed_value", want.removed, got.removed);
        report_field("found_index", VAL_W'(want.found), VAL_W'(got.found));
        report_field("element_count", VAL_W'(want.count), VAL_W'(got.count));
      end
    end
  end

  // stimulus: reset, directed table, then phased random traffic
  initial begin
    int  burst_len;
    int  pick;
    bit  paused_once;
    paused_once = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue_command(directed_rows[i].cmd, directed_rows[i].val,
                    directed_rows[i].known, directed_rows[i].res);
    end

    while (sent_items < TOTAL_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if (!paused_once || $urandom_range(0, 7) == 0) begin
        drain_results();
        paused_once = 1'b1;
      end
      case ($urandom_range(0, 5))
        // fill to capacity, then pushes, a search and a size query on a full list
        0, 1: begin
          while (shadow_count < CAPACITY) begin
            issue_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                          draw_value(), 1'b0, NO_RES);
          end
          repeat ($urandom_range(1, 3)) begin
            issue_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                          draw_value(), 1'b0, NO_RES);
          end
          issue_command(CMD_SEARCH, draw_key(), 1'b0, NO_RES);
          issue_command(CMD_SIZE, $urandom, 1'b0, NO_RES);
        end
        // drain to empty, then commands on an empty list
        2: begin
          while (shadow_count > 0) begin
            issue_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                          $urandom, 1'b0, NO_RES);
          end
          repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 3);
            issue_command((pick == 0) ? CMD_POP_FRONT : (pick == 1) ? CMD_POP_BACK :
                          (pick == 2) ? CMD_SEARCH : CMD_SIZE, $urandom, 1'b0, NO_RES);
          end
        end
        // mixed traffic
        default: begin
          burst_len = $urandom_range(20, 60);
          repeat (burst_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
              issue_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                            draw_value(), 1'b0, NO_RES);
            end else if (pick < 55) begin
              issue_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                            $urandom, 1'b0, NO_RES);
            end else if (pick < 85) begin
              issue_command(CMD_SEARCH, draw_key(), 1'b0, NO_RES);
            end else if (pick < 95) begin
              issue_command(CMD_SIZE, $urandom, 1'b0, NO_RES);
            end else begin
              issue_command($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI,
                            $urandom, 1'b0, NO_RES);
            end
          end
        end
      endcase
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pend_wr == pend_rd) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[bounded_deque_with_search.f]
src/bdq_pkg.sv
src/bdq_datapath.sv
src/bdq_ctrl.sv
src/bounded_deque_with_search.sv
bench/tb_bounded_deque_with_search.sv
